// ===== src/wps_pkg.sv =====
// shared types, widths, codes and constants of the waypoint heading steering block
package wps_pkg;

   // field widths
   localparam int MODE_W = 2;
   localparam int LAT_W = 31;
   localparam int LON_W = 32;
   localparam int SCL_W = 33;
   localparam int ANG_W = 16;
   localparam int CMD_W = 7;
   localparam int ACMD_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 33;

   // local frame arithmetic
   localparam int DIFF_W = LON_W + 1;
   localparam int POS_W = 48;
   localparam int DELTA_W = POS_W + 1;
   localparam int LOCAL_SHIFT = 18;

   // shared multiplier: magnitude times one half of a scale
   localparam int MUL_A_W = DIFF_W;
   localparam int MUL_B_W = 17;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W = MUL_A_W + 2 * MUL_B_W;

   // cordic
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int ITER_W = $clog2(TABLE_LEN);
   localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_ITERS - 1);
   localparam int CORDIC_W = DELTA_W + 3;
   localparam int Z_W = 32;
   localparam logic [Z_W-1:0] Z_HALF_TURN = 32'h8000_0000;
   localparam logic [Z_W-1:0] Z_ROUND = 32'h0000_8000;
   localparam logic [ANG_W-1:0] QUARTER_TURN = 16'd16384;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_FIX = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAYPOINT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HEADING = 2'd2;

   // known flag bits
   localparam int FLAG_POS = 0;
   localparam int FLAG_WPT = 1;
   localparam int FLAG_HDG = 2;
   localparam int FLAG_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_LATITUDE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_LONGITUDE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LATITUDE_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONGITUDE_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECLINATION = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_SPEED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_GAIN = 3'd6;

   // register reset values
   localparam logic signed [LAT_W-1:0] ORIGIN_LAT_RST = 31'sd422933538;
   localparam logic signed [LON_W-1:0] ORIGIN_LON_RST = -32'sd712635873;
   localparam logic [SCL_W-1:0] LAT_SCL_RST = 33'd7279670299;
   localparam logic [SCL_W-1:0] LON_SCL_RST = 33'd5404695643;
   localparam logic signed [ANG_W-1:0] DECL_RST = 16'sd2660;
   localparam logic [CMD_W-1:0] SPEED_RST = 7'd60;
   localparam logic [CMD_W-1:0] GAIN_RST = 7'd60;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_ABS,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACC,
      ST_STORE,
      ST_CHECK,
      ST_DELTA,
      ST_CORDIC,
      ST_ROUND,
      ST_ERR_MUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_status_type;

   // atan(2^-i) as 32-bit binary angle
   function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [Z_W-1:0] val;
      unique case (idx)
         5'd0: val = 32'd536870912;
         5'd1: val = 32'd316933406;
         5'd2: val = 32'd167458907;
         5'd3: val = 32'd85004756;
         5'd4: val = 32'd42667331;
         5'd5: val = 32'd21354465;
         5'd6: val = 32'd10679838;
         5'd7: val = 32'd5340245;
         5'd8: val = 32'd2670163;
         5'd9: val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== src/wps_ifs.sv =====
// valid/ready channel interfaces of the steering block
interface wps_req_if;
   import wps_pkg::*;
   logic valid;
   logic ready;
   logic [MODE_W-1:0] mode;
   logic signed [LAT_W-1:0] latitude;
   logic signed [LON_W-1:0] longitude;
   logic signed [ANG_W-1:0] heading_raw;
   modport source(output valid, mode, latitude, longitude, heading_raw, input ready);
   modport sink(input valid, mode, latitude, longitude, heading_raw, output ready);
endinterface

interface wps_rsp_if;
   import wps_pkg::*;
   logic valid;
   logic ready;
   logic [CMD_W-1:0] linear_command;
   logic signed [ACMD_W-1:0] angular_command;
   modport source(output valid, linear_command, angular_command, input ready);
   modport sink(input valid, linear_command, angular_command, output ready);
endinterface

interface wps_csr_if;
   import wps_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== src/wps_mul.sv =====
// shared registered unsigned multiplier
module wps_mul (
   input logic clock,
   input logic en,
   input logic [wps_pkg::MUL_A_W-1:0] a,
   input logic [wps_pkg::MUL_B_W-1:0] b,
   output logic [wps_pkg::PROD_W-1:0] product
);
   import wps_pkg::*;

   logic [PROD_W-1:0] full;
   logic [PROD_W-1:0] product_ff;

   assign full = a * b;

   // product holds while not enabled
   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= full;
      end
   end

   assign product = product_ff;
endmodule

// ===== src/wps_cordic.sv =====
// iterative vectoring cordic, one rotation per cycle
module wps_cordic (
   input logic clock,
   input logic reset,
   input logic start,
   input logic signed [wps_pkg::DELTA_W-1:0] x_start,
   input logic signed [wps_pkg::DELTA_W-1:0] y_start,
   output wps_pkg::cordic_status_type status,
   output logic [wps_pkg::Z_W-1:0] angle
);
   import wps_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_start_ext, xs;
   logic signed [CORDIC_W-1:0] y_ff, y_start_ext, ys;
   logic signed [CORDIC_W-1:0] x_in, y_in;
   logic [Z_W-1:0] z_ff, z_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   assign x_start_ext = $signed({{(CORDIC_W - DELTA_W){x_start[DELTA_W-1]}}, x_start});
   assign y_start_ext = $signed({{(CORDIC_W - DELTA_W){y_start[DELTA_W-1]}}, y_start});
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // fold the left half plane onto the right
         if (x_start_ext < 0) begin
            x_in = -x_start_ext;
            y_in = -y_start_ext;
            z_in = Z_HALF_TURN;
         end else begin
            x_in = x_start_ext;
            y_in = y_start_ext;
            z_in = '0;
         end
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_entry(cnt_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_entry(cnt_ff);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CORDIC_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign angle = z_ff;
endmodule

// ===== src/waypoint_heading_steering_unit.sv =====
// top level of the waypoint heading steering block
//
// req_chan carries one update per transfer: a position fix, a waypoint (both in
// 1e-7 degrees) or a compass heading, chosen by mode. csr_chan writes the seven
// configuration registers by index; it is always ready and is meant to be used
// while no update is in flight. rsp_chan carries the linear and angular command.
//
// An update is taken only while the sequencer is idle. A fix or waypoint goes
// through local frame conversion (two axes, each through the shared 33x17
// multiplier in two halves). Once position, waypoint and heading are all
// known, a result passes through the delta step, the iterative cordic (16
// rotations and a step to flag completion), rounding, the error multiply and
// the emit step; the next update is taken only once the sequencer is back in
// idle, so updates are not overlapped. An update of an unused mode, one before
// all three are known, or one that leaves coincident points gives no result
// and returns the block to idle.
//
// The result sits in an output register; the next update is taken while it
// waits. If the receiver still stalls when the next result is due, the
// sequencer holds in its last step. Reset clears the known positions, heading
// and flags and loads the register defaults.
module waypoint_heading_steering_unit (
   input logic clock,
   input logic reset,
   wps_req_if.sink req_chan,
   wps_rsp_if.source rsp_chan,
   wps_csr_if.sink csr_chan
);
   import wps_pkg::*;

   state_type state_ff, state_in;

   // configuration
   logic signed [LAT_W-1:0] olat_ff;
   logic signed [LON_W-1:0] olon_ff;
   logic [SCL_W-1:0] lat_scl_ff, lon_scl_ff;
   logic signed [ANG_W-1:0] decl_ff;
   logic [CMD_W-1:0] speed_ff, gain_ff;

   // block state
   logic signed [POS_W-1:0] robot_east_ff, robot_north_ff;
   logic signed [POS_W-1:0] target_east_ff, target_north_ff;
   logic [ANG_W-1:0] heading_ff;
   logic [FLAG_W-1:0] flags_ff;

   // working registers
   logic [MODE_W-1:0] mode_ff;
   logic signed [LAT_W-1:0] lat_ff;
   logic signed [LON_W-1:0] lon_ff;
   logic axis_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [MUL_A_W-1:0] mag_ff;
   logic neg_ff;
   logic [ACC_W-1:0] acc_ff;
   logic signed [DELTA_W-1:0] de_ff, dn_ff;
   logic [ANG_W-1:0] err_ff;

   // output register
   logic rsp_valid_ff;
   logic [CMD_W-1:0] lin_ff;
   logic signed [ACMD_W-1:0] ang_ff;

   // control
   logic req_ready;
   logic mul_en;
   logic cordic_start;
   logic out_free;
   logic accept;
   logic delta_zero;

   // datapath signals
   logic [SCL_W-1:0] scl_sel;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0] prod;
   logic [POS_W-1:0] local_mag;
   logic signed [POS_W-1:0] local_val;
   logic [Z_W-1:0] rounded;
   logic [ANG_W-1:0] bearing;
   logic [ANG_W-1:0] err_mag;
   logic [ACMD_W-1:0] quot;
   logic [Z_W-1:0] angle;
   cordic_status_type cordic_status;

   assign accept = req_chan.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign delta_zero = (de_ff == '0) && (dn_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.mode)
                  MODE_FIX, MODE_WAYPOINT: state_in = ST_DIFF;
                  MODE_HEADING: state_in = ST_CHECK;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIFF: state_in = ST_ABS;
         ST_ABS: state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_ACC;
         ST_ACC: state_in = ST_STORE;
         ST_STORE: state_in = axis_ff ? ST_CHECK : ST_DIFF;
         ST_CHECK: state_in = (flags_ff == {FLAG_W{1'b1}}) ? ST_DELTA : ST_IDLE;
         ST_DELTA: state_in = delta_zero ? ST_IDLE : ST_CORDIC;
         ST_CORDIC: state_in = cordic_status.done ? ST_ROUND : ST_CORDIC;
         ST_ROUND: state_in = ST_ERR_MUL;
         ST_ERR_MUL: state_in = ST_EMIT;
         ST_EMIT: state_in = out_free ? ST_IDLE : ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      mul_en = 1'b0;
      cordic_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL_LO, ST_MUL_HI, ST_ERR_MUL: mul_en = 1'b1;
         ST_DELTA: cordic_start = !delta_zero;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         olat_ff <= ORIGIN_LAT_RST;
         olon_ff <= ORIGIN_LON_RST;
         lat_scl_ff <= LAT_SCL_RST;
         lon_scl_ff <= LON_SCL_RST;
         decl_ff <= DECL_RST;
         speed_ff <= SPEED_RST;
         gain_ff <= GAIN_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ORIGIN_LATITUDE: olat_ff <= $signed(csr_chan.data[LAT_W-1:0]);
            CSR_ORIGIN_LONGITUDE: olon_ff <= $signed(csr_chan.data[LON_W-1:0]);
            CSR_LATITUDE_SCALE: lat_scl_ff <= csr_chan.data[SCL_W-1:0];
            CSR_LONGITUDE_SCALE: lon_scl_ff <= csr_chan.data[SCL_W-1:0];
            CSR_DECLINATION: decl_ff <= $signed(csr_chan.data[ANG_W-1:0]);
            CSR_FORWARD_SPEED: speed_ff <= csr_chan.data[CMD_W-1:0];
            CSR_TURN_GAIN: gain_ff <= csr_chan.data[CMD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // local frame conversion: east from longitude, north from latitude
   always_comb begin
      if (axis_ff) begin
         diff_in = $signed({{(DIFF_W - LAT_W){olat_ff[LAT_W-1]}}, olat_ff})
            - $signed({{(DIFF_W - LAT_W){lat_ff[LAT_W-1]}}, lat_ff});
         scl_sel = lat_scl_ff;
      end else begin
         diff_in = $signed({{(DIFF_W - LON_W){olon_ff[LON_W-1]}}, olon_ff})
            - $signed({{(DIFF_W - LON_W){lon_ff[LON_W-1]}}, lon_ff});
         scl_sel = lon_scl_ff;
      end
   end

   assign err_mag = err_ff[ANG_W-1] ? (~err_ff + 1'b1) : err_ff;

   always_comb begin
      if (state_ff == ST_ERR_MUL) begin
         mul_a = {{(MUL_A_W - ANG_W){1'b0}}, err_mag};
         mul_b = {{(MUL_B_W - CMD_W){1'b0}}, gain_ff};
      end else if (state_ff == ST_MUL_HI) begin
         mul_a = mag_ff;
         mul_b = {{(2 * MUL_B_W - SCL_W){1'b0}}, scl_sel[SCL_W-1:MUL_B_W]};
      end else begin
         mul_a = mag_ff;
         mul_b = scl_sel[MUL_B_W-1:0];
      end
   end

   wps_mul u_mul (
      .clock(clock),
      .en(mul_en),
      .a(mul_a),
      .b(mul_b),
      .product(prod)
   );

   assign local_mag = acc_ff[LOCAL_SHIFT + POS_W - 1:LOCAL_SHIFT];
   assign local_val = neg_ff ? -$signed(local_mag) : $signed(local_mag);

   wps_cordic u_cordic (
      .clock(clock),
      .reset(reset),
      .start(cordic_start),
      .x_start(de_ff),
      .y_start(dn_ff),
      .status(cordic_status),
      .angle(angle)
   );

   assign rounded = angle + Z_ROUND;
   assign bearing = rounded[Z_W-1:Z_W-ANG_W] - QUARTER_TURN;
   // truncate toward zero: divide the magnitude, then restore the sign
   assign quot = prod[ANG_W + ACMD_W - 2:ANG_W - 1];

   // state held across updates
   always_ff @(posedge clock) begin
      if (reset) begin
         robot_east_ff <= '0;
         robot_north_ff <= '0;
         target_east_ff <= '0;
         target_north_ff <= '0;
         heading_ff <= '0;
         flags_ff <= '0;
      end else begin
         if (accept && (req_chan.mode == MODE_HEADING)) begin
            heading_ff <= req_chan.heading_raw + decl_ff;
            flags_ff[FLAG_HDG] <= 1'b1;
         end
         if (state_ff == ST_STORE) begin
            unique case ({mode_ff == MODE_WAYPOINT, axis_ff})
               2'b00: robot_east_ff <= local_val;
               2'b01: begin
                  robot_north_ff <= local_val;
                  flags_ff[FLAG_POS] <= 1'b1;
               end
               2'b10: target_east_ff <= local_val;
               default: begin
                  target_north_ff <= local_val;
                  flags_ff[FLAG_WPT] <= 1'b1;
               end
            endcase
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_chan.mode;
         lat_ff <= req_chan.latitude;
         lon_ff <= req_chan.longitude;
      end
      unique case (state_ff)
         ST_IDLE: axis_ff <= 1'b0;
         ST_DIFF: diff_ff <= diff_in;
         ST_ABS: begin
            neg_ff <= diff_ff[DIFF_W-1];
            mag_ff <= diff_ff[DIFF_W-1] ? MUL_A_W'(-diff_ff) : MUL_A_W'(diff_ff);
         end
         ST_MUL_HI: acc_ff <= {{(ACC_W - PROD_W){1'b0}}, prod};
         ST_ACC: acc_ff <= acc_ff + {prod[ACC_W - MUL_B_W - 1:0], {MUL_B_W{1'b0}}};
         ST_STORE: axis_ff <= 1'b1;
         ST_CHECK: begin
            de_ff <= $signed({target_east_ff[POS_W-1], target_east_ff})
               - $signed({robot_east_ff[POS_W-1], robot_east_ff});
            dn_ff <= $signed({target_north_ff[POS_W-1], target_north_ff})
               - $signed({robot_north_ff[POS_W-1], robot_north_ff});
         end
         ST_ROUND: err_ff <= bearing - heading_ff;
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMIT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && out_free) begin
         lin_ff <= speed_ff;
         ang_ff <= err_ff[ANG_W-1] ? -$signed(quot) : $signed(quot);
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.linear_command = lin_ff;
   assign rsp_chan.angular_command = ang_ff;

   // the cordic only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      cordic_status.busy |-> (state_ff == ST_CORDIC))
      else $error("cordic busy outside its sequencer step");

   assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !cordic_status.busy)
      else $error("update taken while cordic busy");

   // a new result only comes out of the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit step");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && (state_ff == ST_EMIT)) |=> (state_ff == ST_EMIT))
      else $error("pending result overwritten");
endmodule
